>>> design/cusum_traffic_change_detector_macros.svh
// assertion macros for the cusum traffic change detector checker
// no dependencies; included by the checker file
`ifndef CUSUM_TRAFFIC_CHANGE_DETECTOR_MACROS_SVH
`define CUSUM_TRAFFIC_CHANGE_DETECTOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctd checker: property failed");

// next-cycle implication, disabled in reset
`define CTD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctd checker: property failed");

// next-cycle implication, active through reset
`define CTD_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ctd checker: property failed");

`endif

>>> design/ctd_pkg.sv
// shared types and constants for the cusum traffic change detector
// no dependencies
package ctd_pkg;

    localparam int NUM_FEAT  = 4;
    localparam int VAL_W     = 48;
    localparam int W_W       = 17;
    localparam int CNT_W     = 16;
    localparam int TALLY_W   = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 48;
    localparam int EWMA_SHIFT = 16;

    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [W_W-1:0]     t_weight;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [TALLY_W-1:0] t_tally;

    localparam t_val    VAL_MAX    = '1;
    localparam t_weight WEIGHT_ONE = t_weight'(65536);
    localparam t_val    EWMA_ROUND = t_val'(32768);

    localparam t_val    RST_THRESHOLD = t_val'(65536);
    localparam t_val    RST_DRIFT     = t_val'(6554);
    localparam t_weight RST_WEIGHT    = t_weight'(19661);
    localparam t_count  RST_WARMUP    = t_count'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 4'd0,
        CFG_DRIFT     = 4'd1,
        CFG_WEIGHT    = 4'd2,
        CFG_WARMUP    = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic    adv;
        logic    warm;
        t_weight weight;
    } t_ewma_ctl;

    typedef struct packed {
        logic adv;
        t_val drift;
    } t_cusum_ctl;

endpackage

>>> design/ctd_ifs.sv
// channel interfaces for the cusum traffic change detector
// depends on ctd_pkg
interface ctd_in_if #(parameter int FEATURE_BITS = 32);
    logic                    valid;
    logic                    ready;
    logic [FEATURE_BITS-1:0] pkt_rate;
    logic [FEATURE_BITS-1:0] octet_rate;
    logic [FEATURE_BITS-1:0] flow_rate;
    logic [FEATURE_BITS-1:0] size_spread;

    modport source (output valid, pkt_rate, octet_rate, flow_rate, size_spread,
                    input ready);
    modport sink   (input valid, pkt_rate, octet_rate, flow_rate, size_spread,
                    output ready);
endinterface

interface ctd_out_if import ctd_pkg::*; ;
    logic   valid;
    logic   ready;
    logic   attack_flag;
    logic   pkt_rate_alarm;
    logic   octet_rate_alarm;
    logic   flow_rate_alarm;
    logic   size_spread_alarm;
    t_tally attack_total;

    modport source (output valid, attack_flag, pkt_rate_alarm, octet_rate_alarm,
                    flow_rate_alarm, size_spread_alarm, attack_total,
                    input ready);
    modport sink   (input valid, attack_flag, pkt_rate_alarm, octet_rate_alarm,
                    flow_rate_alarm, size_spread_alarm, attack_total,
                    output ready);
endinterface

interface ctd_cfg_if import ctd_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/cusum_traffic_change_detector.sv
// top level of the cusum traffic change detector: config, pipeline control, output
// depends on ctd_pkg, ctd_ifs, ctd_ewma_lane, ctd_cusum_lane
//
//  channel  dir  payload                                        transaction when
//  i_in     in   four feature rates                             valid & ready
//  o_out    out  attack flag, four alarms, attack total         valid & ready
//  i_cfg    in   register index, write data                     valid & ready
//
// one window per cycle sustained while the output is not stalled; each result is registered in every stage below
// stages: input register, baseline update, cusum update, output register
// each state loop (baseline, cusum, tally) closes within one stage
// synchronous reset clears baselines, sums, counters and all valid flags
// a stalled output holds its item while earlier empty stages keep filling
module cusum_traffic_change_detector
    import ctd_pkg::*;
#(
    parameter int FEATURE_BITS  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctd_in_if.sink    i_in,
    ctd_out_if.source o_out,
    ctd_cfg_if.sink   i_cfg
);

    t_val    r_threshold;
    t_val    r_drift;
    t_weight r_weight;
    t_count  r_warmup;
    t_count  r_windows;
    t_tally  r_tally;
    t_tally  n_tally;

    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;

    logic out_free;
    logic s3_free;
    logic s2_free;
    logic adv1;
    logic adv2;
    logic adv3;

    logic [FEATURE_BITS-1:0] r_raw [NUM_FEAT];
    t_val                    lane_x [NUM_FEAT];
    t_val                    lane_base [NUM_FEAT];
    t_val                    lane_sum [NUM_FEAT];
    logic [NUM_FEAT-1:0]     alarm;
    logic [NUM_FEAT-1:0]     r_out_alarm;
    logic                    any;
    t_tally                  r_out_total;

    t_ewma_ctl  ewma_ctl;
    t_cusum_ctl cusum_ctl;

    // config port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_drift     <= RST_DRIFT;
            r_weight    <= RST_WEIGHT;
            r_warmup    <= RST_WARMUP;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESHOLD: r_threshold <= i_cfg.data[VAL_W-1:0];
                CFG_DRIFT:     r_drift     <= i_cfg.data[VAL_W-1:0];
                CFG_WEIGHT:    r_weight    <= i_cfg.data[W_W-1:0];
                CFG_WARMUP:    r_warmup    <= i_cfg.data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // stage advance
    assign out_free = !r_out_valid || o_out.ready;
    assign adv3     = r_s3_valid && out_free;
    assign s3_free  = !r_s3_valid || out_free;
    assign adv2     = r_s2_valid && s3_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign adv1     = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_raw[0] <= i_in.pkt_rate;
            r_raw[1] <= i_in.octet_rate;
            r_raw[2] <= i_in.flow_rate;
            r_raw[3] <= i_in.size_spread;
        end
    end

    // warmup window count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_windows <= '0;
        end else if (adv1 && r_windows != '1) begin
            r_windows <= r_windows + 1'b1;
        end
    end

    assign ewma_ctl.adv    = adv1;
    assign ewma_ctl.warm   = r_windows < r_warmup;
    assign ewma_ctl.weight = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;

    assign cusum_ctl.adv   = adv2;
    assign cusum_ctl.drift = r_drift;

    for (genvar g = 0; g < NUM_FEAT; g++) begin : g_lane
        ctd_ewma_lane #(
            .FEATURE_BITS  (FEATURE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_ewma (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ewma_ctl),
            .i_raw   (r_raw[g]),
            .o_x     (lane_x[g]),
            .o_base  (lane_base[g])
        );

        ctd_cusum_lane u_cusum (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cusum_ctl),
            .i_x     (lane_x[g]),
            .i_base  (lane_base[g]),
            .o_sum   (lane_sum[g])
        );

        assign alarm[g] = lane_sum[g] > r_threshold;
    end

    // attack tally
    assign any     = |alarm;
    assign n_tally = (any && r_tally != '1) ? r_tally + 1'b1 : r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (adv3) begin
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_out_alarm <= alarm;
            r_out_total <= n_tally;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.attack_flag       = |r_out_alarm;
    assign o_out.pkt_rate_alarm    = r_out_alarm[0];
    assign o_out.octet_rate_alarm  = r_out_alarm[1];
    assign o_out.flow_rate_alarm   = r_out_alarm[2];
    assign o_out.size_spread_alarm = r_out_alarm[3];
    assign o_out.attack_total      = r_out_total;

endmodule

>>> design/ctd_ewma_lane.sv
// one feature lane: sample widening and ewma baseline state
// depends on ctd_pkg
module ctd_ewma_lane
    import ctd_pkg::*;
#(
    parameter int FEATURE_BITS  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ewma_ctl               i_ctl,
    input  logic [FEATURE_BITS-1:0] i_raw,
    output t_val                    o_x,
    output t_val                    o_base
);

    localparam int WIDE_W = 64;
    localparam int ACC_W  = VAL_W + W_W;

    logic [WIDE_W-1:0] wide;
    t_val              x;
    t_weight           keep;
    logic [ACC_W-1:0]  prod_b;
    logic [ACC_W-1:0]  prod_x;
    logic [ACC_W-1:0]  acc;
    t_val              smooth;
    t_val              r_base;
    t_val              n_base;
    t_val              r_x;

    assign wide = WIDE_W'(i_raw) << FRACTION_BITS;
    assign x    = (|wide[WIDE_W-1:VAL_W]) ? VAL_MAX : wide[VAL_W-1:0];

    assign keep   = WEIGHT_ONE - i_ctl.weight;
    assign prod_b = ACC_W'(r_base) * ACC_W'(keep);
    assign prod_x = ACC_W'(x) * ACC_W'(i_ctl.weight);
    assign acc    = prod_b + prod_x + ACC_W'(EWMA_ROUND);
    assign smooth = acc[VAL_W+EWMA_SHIFT-1:EWMA_SHIFT];

    assign n_base = i_ctl.warm ? x : smooth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_ctl.adv) begin
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_x <= x;
        end
    end

    assign o_x    = r_x;
    assign o_base = r_base;

endmodule

>>> design/ctd_cusum_lane.sv
// one feature lane: one-sided cusum state with clamp and saturation
// depends on ctd_pkg
module ctd_cusum_lane
    import ctd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cusum_ctl i_ctl,
    input  t_val       i_x,
    input  t_val       i_base,
    output t_val       o_sum
);

    logic [VAL_W:0] up;
    logic [VAL_W:0] down;
    logic [VAL_W:0] diff;
    t_val           r_sum;
    t_val           n_sum;

    assign up   = {1'b0, r_sum} + {1'b0, i_x};
    assign down = {1'b0, i_base} + {1'b0, i_ctl.drift};
    assign diff = up - down;

    always_comb begin
        if (up <= down) begin
            n_sum = '0;
        end else if (diff[VAL_W]) begin
            n_sum = VAL_MAX;
        end else begin
            n_sum = diff[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.adv) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> design/ctd_checker.sv
// port-level checker for the cusum traffic change detector, bound to the top level
// depends on ctd_pkg and cusum_traffic_change_detector_macros.svh
`include "cusum_traffic_change_detector_macros.svh"

module ctd_checker
    import ctd_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_attack_flag,
    input logic   i_pr_alarm,
    input logic   i_br_alarm,
    input logic   i_cr_alarm,
    input logic   i_ss_alarm,
    input t_tally i_attack_total
);

    logic                 any_alarm;
    logic                 flagged;
    logic                 stalled;
    logic [TALLY_W+4:0]   out_word;

    assign any_alarm = i_pr_alarm || i_br_alarm || i_cr_alarm || i_ss_alarm;
    assign flagged   = i_out_valid && i_attack_flag;
    assign stalled   = i_out_valid && !i_out_ready;
    assign out_word  = {i_attack_flag, i_pr_alarm, i_br_alarm, i_cr_alarm, i_ss_alarm,
                        i_attack_total};

    `CTD_ASSERT_SAME(a_flag_is_or, i_clk, i_rst_n, i_out_valid, i_attack_flag == any_alarm)
    `CTD_ASSERT_SAME(a_total_counts_flag, i_clk, i_rst_n, flagged, i_attack_total != '0)
    `CTD_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !i_out_valid)
    `CTD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, stalled, i_out_valid && $stable(out_word))

endmodule

bind cusum_traffic_change_detector ctd_checker u_ctd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_attack_flag  (o_out.attack_flag),
    .i_pr_alarm     (o_out.pkt_rate_alarm),
    .i_br_alarm     (o_out.octet_rate_alarm),
    .i_cr_alarm     (o_out.flow_rate_alarm),
    .i_ss_alarm     (o_out.size_spread_alarm),
    .i_attack_total (o_out.attack_total)
);
